>>> hdl/mh2_pkg.sv
// Shared constants, types and helpers for the MurmurHash64A block.
package mh2_pkg;

  localparam int unsigned HashW  = 64;
  localparam int unsigned HalfW  = HashW / 2;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW   = 31;
  localparam int unsigned WordBytes = HashW / 8;

  localparam logic [HashW-1:0] MulConst = 64'hc6a4a7935bd1e995;
  localparam int unsigned      ShiftR   = 47;

  // Request to and response from the shared multiplier.
  typedef struct packed {
    logic             start;
    logic [HashW-1:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] product;
  } mul_rsp_t;

  function automatic logic [HashW-1:0] xor_shift(input logic [HashW-1:0] x);
    return x ^ (x >> ShiftR);
  endfunction

endpackage

>>> hdl/mh2_mul.sv
// Multi-cycle 64-bit low-product multiply by the hash constant on one 32x32 multiplier.
module mh2_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mh2_pkg::mul_req_t req_i,
  output mh2_pkg::mul_rsp_t rsp_o
);

  localparam logic [mh2_pkg::HalfW-1:0] MulLo = mh2_pkg::MulConst[mh2_pkg::HalfW-1:0];
  localparam logic [mh2_pkg::HalfW-1:0] MulHi =
    mh2_pkg::MulConst[mh2_pkg::HashW-1:mh2_pkg::HalfW];

  logic                       run_q;
  logic                       done_q;
  logic [1:0]                 step_q;
  logic [mh2_pkg::HashW-1:0]  a_q;
  logic [mh2_pkg::HashW-1:0]  acc_q;
  logic [mh2_pkg::HalfW-1:0]  op_a;
  logic [mh2_pkg::HalfW-1:0]  op_b;
  logic [mh2_pkg::HashW-1:0]  prod;

  // step 0: aL*ML, step 1: + aH*ML <<32, step 2: + aL*MH <<32
  assign op_a = (step_q == 2'd1) ? a_q[mh2_pkg::HashW-1:mh2_pkg::HalfW]
                                 : a_q[mh2_pkg::HalfW-1:0];
  assign op_b = (step_q == 2'd2) ? MulHi : MulLo;
  assign prod = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (run_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd2) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.operand;
    end else if (run_q) begin
      if (step_q == 2'd0) begin
        acc_q <= prod;
      end else begin
        acc_q[mh2_pkg::HashW-1:mh2_pkg::HalfW] <=
          acc_q[mh2_pkg::HashW-1:mh2_pkg::HalfW] + prod[mh2_pkg::HalfW-1:0];
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

>>> hdl/murmur2_64_hash.sv
// MurmurHash64A: one 64-bit constant multiply shared by all steps under a small sequencer.
// Each multiply holds the sequencer until it is done; dispatch follows the input transfer.
// Multiplies per item: 3 for a full word, 1 for a tail, 0 for no bytes, plus one seed multiply
// for a first item and one finalize multiply for a last item, more wait if the output is full; ready only when idle.
// Hash is registered once the finalize multiply ends and the output register is free, and is held until taken.
// rst_ni is asynchronous, active low; it clears seed, running hash and the sequencer.
module murmur2_64_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mh2_pkg::SeedW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mh2_pkg::HashW-1:0]    data_word_i,
  input  logic [mh2_pkg::CountW-1:0]   byte_count_i,
  input  logic [mh2_pkg::LenW-1:0]     total_length_i,
  input  logic                         first_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mh2_pkg::HashW-1:0]    hash_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SEED = 7'b0000010,
    S_DISP = 7'b0000100,
    S_K1   = 7'b0001000,
    S_K2   = 7'b0010000,
    S_H    = 7'b0100000,
    S_F    = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [mh2_pkg::SeedW-1:0]       seed_q;
  logic [mh2_pkg::HashW-1:0]       hash_q, hash_d;
  logic [mh2_pkg::HashW-1:0]       word_q;
  logic [mh2_pkg::CountW-1:0]      cnt_q;
  logic                            last_q;
  logic                            out_valid_q;
  logic [mh2_pkg::HashW-1:0]       res_q;
  logic                            res_load;
  logic                            in_fire;
  logic [mh2_pkg::HashW-1:0]       tail_mask;
  mh2_pkg::mul_req_t               mul_req;
  mh2_pkg::mul_rsp_t               mul_rsp;

  mh2_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign hash_o      = res_q;

  // keep the low cnt_q bytes of the word
  always_comb begin
    for (int i = 0; i < mh2_pkg::WordBytes; i++) begin
      tail_mask[i*8 +: 8] = (4'(i) < cnt_q) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_d          = state_q;
    hash_d           = hash_q;
    res_load         = 1'b0;
    mul_req.start    = 1'b0;
    mul_req.operand  = hash_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (first_i) begin
            mul_req.start   = 1'b1;
            mul_req.operand = {{(mh2_pkg::HashW-mh2_pkg::LenW){1'b0}}, total_length_i};
            state_d         = S_SEED;
          end else begin
            state_d = S_DISP;
          end
        end
      end
      S_SEED: begin
        if (mul_rsp.done) begin
          hash_d  = {{(mh2_pkg::HashW-mh2_pkg::SeedW){1'b0}}, seed_q} ^ mul_rsp.product;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        priority if (cnt_q == 4'(mh2_pkg::WordBytes)) begin
          mul_req.start   = 1'b1;
          mul_req.operand = word_q;
          state_d         = S_K1;
        end else if (cnt_q != '0) begin
          mul_req.start   = 1'b1;
          mul_req.operand = hash_q ^ (word_q & tail_mask);
          state_d         = S_H;
        end else if (last_q) begin
          mul_req.start   = 1'b1;
          mul_req.operand = mh2_pkg::xor_shift(hash_q);
          state_d         = S_F;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_K1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = mh2_pkg::xor_shift(mul_rsp.product);
          state_d         = S_K2;
        end
      end
      S_K2: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = hash_q ^ mul_rsp.product;
          state_d         = S_H;
        end
      end
      S_H: begin
        if (mul_rsp.done) begin
          if (last_q) begin
            mul_req.start   = 1'b1;
            mul_req.operand = mh2_pkg::xor_shift(mul_rsp.product);
            state_d         = S_F;
          end else begin
            hash_d  = mul_rsp.product;
            state_d = S_IDLE;
          end
        end
      end
      S_F: begin
        // wait for the output register to free up
        if (mul_rsp.done && (!out_valid_q || out_ready_i)) begin
          res_load = 1'b1;
          hash_d   = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= '0;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      word_q <= data_word_i;
      cnt_q  <= (byte_count_i > 4'(mh2_pkg::WordBytes)) ? 4'(mh2_pkg::WordBytes)
                                                         : byte_count_i;
      last_q <= last_i;
    end
    if (res_load) begin
      res_q <= mh2_pkg::xor_shift(mul_rsp.product);
    end
  end

endmodule

>>> hdl/mh2_checker.sv
// Port-level assertions for the MurmurHash64A block, bound to the top level.
module mh2_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [mh2_pkg::HashW-1:0]  hash_o
);

  // a result waiting for the sink stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hash_o))
    else $error("result changed while stalled");

  // one item at a time: a transfer makes the block busy
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item in flight");

  // a new result shows up only as the sequencer finishes an item
  a_result_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result appeared outside item completion");

endmodule

bind murmur2_64_hash mh2_checker u_mh2_checker (.*);
